// ===== design/linear_probe_route_table_assert.svh =====
// Assertion macros shared by the route table RTL.
// LPRT_ASSERT_IMPL: same-cycle implication, checked at every rising edge out of reset.
// LPRT_ASSERT_NEXT: next-cycle implication, checked at every rising edge out of reset.
`ifndef LINEAR_PROBE_ROUTE_TABLE_ASSERT_SVH
`define LINEAR_PROBE_ROUTE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LPRT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("route table implication check failed");
`define LPRT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("route table next-cycle check failed");
`else
`define LPRT_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define LPRT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/lprt_pkg.sv =====
package lprt_pkg;

    localparam int unsigned KEY_W  = 64;
    localparam int unsigned PATH_W = 32;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned HASH_WORDS = 3;
    localparam logic [16:0] HASH_PRIME = 17'd65521;

    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [KEY_W-1:0]  dest_key;
        logic [PATH_W-1:0] path_in;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PATH_W-1:0] path_out;
    } rsp_t;

    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [PATH_W-1:0] path;
    } slot_entry_t;

endpackage

// ===== design/lprt_slot_ram.sv =====
module lprt_slot_ram #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  lprt_pkg::slot_entry_t     wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output lprt_pkg::slot_entry_t     rd_data
);

    lprt_pkg::slot_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/lprt_hash.sv =====
module lprt_hash #(
    parameter int unsigned SLOTS = 1024,
    parameter int unsigned IDX_W = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lprt_pkg::KEY_W-1:0] key,
    output logic                       done,
    output logic [IDX_W-1:0]           idx
);

    // floor(2^32 / SLOTS): quotient estimate is exact or one low for 16-bit values
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / SLOTS);
    localparam logic [16:0] SLOTS_C = 17'(SLOTS);

    logic [15:0] fold;
    logic [15:0] h_mod;
    logic [15:0] h_reg;
    logic [47:0] prod_reg;
    logic [16:0] rem_reg;
    logic [32:0] qn;
    logic [16:0] red;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;

    always_comb
    begin
        fold = '0;
        for (int w = 0; w < lprt_pkg::HASH_WORDS; w++)
        begin
            fold = fold ^ key[w*lprt_pkg::WORD_W +: lprt_pkg::WORD_W];
        end
    end

    // fold stays below twice the prime: one compare and subtract
    assign h_mod = ({1'b0, fold} >= lprt_pkg::HASH_PRIME)
                 ? 16'({1'b0, fold} - lprt_pkg::HASH_PRIME) : fold;

    assign qn  = {17'b0, prod_reg[47:32]} * {16'b0, SLOTS_C};
    assign red = (rem_reg >= SLOTS_C) ? (rem_reg - SLOTS_C) : rem_reg;
    assign idx = red[IDX_W-1:0];
    assign done = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h_reg <= h_mod;
        end
        prod_reg <= {32'b0, h_reg} * {16'b0, RECIP};
        rem_reg  <= {1'b0, h_reg} - qn[16:0];
    end

endmodule

// ===== design/linear_probe_route_table.sv =====
// Channel | Signals                      | Payload
// --------+------------------------------+------------------------------------
// request | req_valid / req_ready / req  | req_type, dest_key, path_in
// reply   | rsp_valid / rsp_ready / rsp  | status, path_out
//
// One request is in flight at a time. A request passes through the hash,
// then one memory read per slot probed (1 to TABLE_SLOTS slots), then the
// load of its reply; req_ready returns in the cycle after that load.
// After reset the slot memory is swept clear before the first request is
// taken. A waiting reply does not block a new request; the next reply
// holds until it is taken.

`include "linear_probe_route_table_assert.svh"

module linear_probe_route_table #(
    parameter int unsigned TABLE_SLOTS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lprt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lprt_pkg::rsp_t rsp
);

    localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } state_t;

    state_t                state_reg,     state_next;
    logic [IDX_W-1:0]      clr_idx_reg,   clr_idx_next;
    logic [IDX_W-1:0]      idx_reg,       idx_next;
    logic [IDX_W-1:0]      cnt_reg,       cnt_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    lprt_pkg::req_t        req_reg,       req_next;
    lprt_pkg::rsp_t        res_reg,       res_next;
    lprt_pkg::rsp_t        rsp_reg,       rsp_next;

    logic                  hash_start;
    logic                  hash_done;
    logic [IDX_W-1:0]      hash_idx;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    lprt_pkg::slot_entry_t wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    lprt_pkg::slot_entry_t rd_data;

    logic                  key_hit;
    logic                  put_req;
    logic                  load_rsp;
    logic                  res_full;
    logic                  rsp_ok;

    lprt_hash #(
        .SLOTS (TABLE_SLOTS),
        .IDX_W (IDX_W)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (req.dest_key),
        .done  (hash_done),
        .idx   (hash_idx)
    );

    lprt_slot_ram #(
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign key_hit   = (rd_data.key == req_reg.dest_key);
    assign put_req   = (req_reg.req_type == lprt_pkg::REQ_PUT);
    assign load_rsp  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);
    assign res_full  = (res_reg.status == lprt_pkg::STATUS_FULL);
    assign rsp_ok    = (rsp_reg.status == lprt_pkg::STATUS_OK);

    // Probe sequencer. Only the final cycle of a probe writes memory and the
    // next read waits behind the reply load, the idle state and the hash, so a
    // read never meets a pending write to the same slot.
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        hash_start     = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = '{used: 1'b1, key: req_reg.dest_key, path: req_reg.path_in};
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        // drop the reply once taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // sweep one slot per cycle, marking it empty
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = '0;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                // issue the read of the home slot
                if (hash_done)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = hash_idx;
                    idx_next   = hash_idx;
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!rd_data.used || key_hit)
                begin
                    // empty slot or matching key ends the probe
                    if (put_req)
                    begin
                        wr_en    = 1'b1;
                        res_next = '{status: lprt_pkg::STATUS_OK, path_out: '0};
                    end
                    else if (key_hit && rd_data.used)
                    begin
                        res_next = '{status: lprt_pkg::STATUS_OK, path_out: rd_data.path};
                    end
                    else
                    begin
                        res_next = '{status: lprt_pkg::STATUS_MISS, path_out: '0};
                    end
                    state_next = S_DONE;
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    // every slot visited
                    res_next.path_out = '0;
                    res_next.status   = put_req ? lprt_pkg::STATUS_FULL
                                                : lprt_pkg::STATUS_MISS;
                    state_next = S_DONE;
                end
                else
                begin
                    // advance with wrap and read the next slot
                    idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
                    cnt_next = cnt_reg + IDX_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_next;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (load_rsp)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    `LPRT_ASSERT_IMPL(a_write_phase, clk, rst_n, wr_en, state_reg == S_CLEAR || state_reg == S_PROBE)
    `LPRT_ASSERT_IMPL(a_full_on_put, clk, rst_n, (state_reg == S_DONE) && res_full, put_req)
    `LPRT_ASSERT_IMPL(a_path_zero, clk, rst_n, rsp_valid && !rsp_ok, rsp.path_out == '0)
    `LPRT_ASSERT_IMPL(a_home_range, clk, rst_n, hash_done, 32'(hash_idx) < 32'(TABLE_SLOTS))
    `LPRT_ASSERT_NEXT(a_reply_loads, clk, rst_n, load_rsp, rsp_valid && (rsp == $past(res_reg)))

endmodule

// ===== tb/lprt_route_checker.sv =====
// Reply checker for the route table: predicts each reply from the request
// transfers it sees and compares the replies against them in order.
module lprt_route_checker
    import lprt_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatch_count,
    output int   replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    bit                slot_used [TABLE_SLOTS];
    logic [KEY_W-1:0]  slot_key  [TABLE_SLOTS];
    logic [PATH_W-1:0] slot_path [TABLE_SLOTS];
    rsp_t              expected_replies[$];

    // Probe from the home slot; update the shadow table on a put.
    function automatic rsp_t predict_route(req_t r);
        logic [16:0] h;
        int unsigned idx;
        int unsigned n;
        bit          done;
        rsp_t        res;
        h = {1'b0, r.dest_key[15:0] ^ r.dest_key[31:16] ^ r.dest_key[47:32]};
        h = h % HASH_PRIME;
        idx = h % TABLE_SLOTS;
        res.status = (r.req_type == REQ_PUT) ? STATUS_FULL : STATUS_MISS;
        res.path_out = '0;
        done = 1'b0;
        for (n = 0; n < TABLE_SLOTS && !done; n++)
        begin
            if (!slot_used[idx])
            begin
                if (r.req_type == REQ_PUT)
                begin
                    slot_used[idx] = 1'b1;
                    slot_key[idx]  = r.dest_key;
                    slot_path[idx] = r.path_in;
                    res.status     = STATUS_OK;
                end
                done = 1'b1;
            end
            else if (slot_key[idx] == r.dest_key)
            begin
                if (r.req_type == REQ_PUT)
                    slot_path[idx] = r.path_in;
                else
                    res.path_out = slot_path[idx];
                res.status = STATUS_OK;
                done = 1'b1;
            end
            else
            begin
                idx = (idx + 1 == TABLE_SLOTS) ? 0 : idx + 1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        int   errs;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                slot_used[i] = 1'b0;
            expected_replies.delete();
            mismatch_count <= 0;
            replies_due    <= 0;
        end
        else
        begin
            errs = 0;
            // Check the reply first so a stray one is never matched to a
            // request taken at the same edge.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected reply: status %0d path_out %h",
                           rsp.status, rsp.path_out);
                    errs++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        errs++;
                    end
                    if (rsp.path_out !== want.path_out)
                    begin
                        $error("path_out: expected %h, actual %h",
                               want.path_out, rsp.path_out);
                        errs++;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_replies.push_back(predict_route(req));
            mismatch_count <= mismatch_count + errs;
            replies_due    <= expected_replies.size();
        end
    end

endmodule

// ===== tb/tb_linear_probe_route_table.sv =====
// Stimulus and verdict for the route table. The checker beside the block
// does all prediction; this module drives the two channels and reports the verdict.
module tb_linear_probe_route_table;
    timeunit 1ns;
    timeprecision 1ps;
    import lprt_pkg::*;

    localparam int unsigned SLOTS = 1024;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   mismatch_count;
    int   replies_due;

    // Bookkeeping of which keys the table holds, used only to steer
    // stimulus (hits, overwrites, misses, filling the table).
    bit               stored_keys[logic [KEY_W-1:0]];
    logic [KEY_W-1:0] key_list[$];
    int               requests_sent;
    int               replies_taken;

    linear_probe_route_table #(.TABLE_SLOTS(SLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lprt_route_checker #(.TABLE_SLOTS(SLOTS)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .replies_due    (replies_due)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Build a random key whose folded 16-bit hash equals h; every key bit
    // still varies because the two upper hashed words and the unhashed top word are random.
    function automatic logic [KEY_W-1:0] key_for_hash(logic [15:0] h);
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] top;
        w1  = 16'($urandom);
        w2  = 16'($urandom);
        top = 16'($urandom);
        return {top, w2, w1, h ^ w1 ^ w2};
    endfunction

    // Key not yet stored; a hash target below 0 means a fully random key.
    function automatic logic [KEY_W-1:0] fresh_key(int h);
        logic [KEY_W-1:0] k;
        do
        begin
            k = (h < 0) ? {$urandom, $urandom} : key_for_hash(16'(h));
        end
        while (stored_keys.exists(k));
        return k;
    endfunction

    // Hash target inside a narrow window so probe chains grow and merge;
    // windows near the top of the table force wrap-around.
    function automatic int clustered_hash(int unsigned win);
        int unsigned off;
        off = (win + $urandom_range(0, 47)) % SLOTS;
        return int'(($urandom_range(0, 63) << 10) | off);
    endfunction

    // Offer one request and hold it until the transfer. Valid is only
    // dropped when there is a gap, so it never toggles within one step.
    task automatic send_route(logic op, logic [KEY_W-1:0] key, logic [PATH_W-1:0] path);
        int gap;
        gap = ((requests_sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{req_type: op, dest_key: key, path_in: path};
        do @(posedge clk); while (!req_ready);
        // A put of a new key lands only while the table has room.
        if (op == REQ_PUT && !stored_keys.exists(key) && stored_keys.num() < SLOTS)
        begin
            stored_keys[key] = 1'b1;
            key_list.push_back(key);
        end
        requests_sent++;
    endtask

    // Mixed traffic: new puts, overwrites, hits and misses; new_pct sets
    // the share of puts of new keys.
    task automatic mixed_traffic(int count, int new_pct);
        int               r;
        int unsigned      win;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < count; i++)
        begin
            // Move the hot window now and then.
            if (i % 64 == 0)
                win = ($urandom_range(0, 3) == 0) ? SLOTS - 20 : $urandom_range(0, SLOTS - 1);
            r = $urandom_range(0, 99);
            if (r >= new_pct && r < new_pct + 50 && key_list.size() == 0)
                r = 0;
            if (r < new_pct)
            begin
                k = fresh_key(($urandom_range(0, 9) < 7) ? clustered_hash(win) : -1);
                send_route(REQ_PUT, k, $urandom);
            end
            else if (r < new_pct + 20)
            begin
                k = key_list[$urandom_range(0, key_list.size() - 1)];
                send_route(REQ_PUT, k, $urandom);
            end
            else if (r < new_pct + 50)
            begin
                k = key_list[$urandom_range(0, key_list.size() - 1)];
                send_route(REQ_GET, k, $urandom);
            end
            else
            begin
                send_route(REQ_GET, fresh_key(clustered_hash(win)), $urandom);
            end
        end
    endtask

    // Receiver: random ready gaps, no-gap stretches, and one long hold-off
    // so the reply register and the block behind it back up.
    initial
    begin
        int gap;
        bit held;
        rsp_ready = 1'b0;
        held      = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (!held && replies_taken >= 120)
            begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (500) @(posedge clk);
            end
            gap = ((replies_taken / 200) % 3 == 2) ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            replies_taken++;
        end
    end

    initial
    begin
        int unsigned fill_slot;
        req_valid     = 1'b0;
        req           = '0;
        rst_n         = 1'b0;
        requests_sent = 0;
        replies_taken = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on an empty table.
        // Get on an empty table misses.
        send_route(REQ_GET, 64'h0, 32'h0);
        // Extremes of key and path.
        send_route(REQ_PUT, 64'h0, 32'h0);
        send_route(REQ_PUT, '1, '1);
        send_route(REQ_GET, 64'h0, '1);
        send_route(REQ_GET, '1, 32'h0);
        // Overwrite in place.
        send_route(REQ_PUT, 64'h0, 32'hA5A5_A5A5);
        send_route(REQ_GET, 64'h0, 32'h0);
        // Same home slot 0: differs only in unhashed bits, hash reduced by
        // the prime, words that cancel out.
        send_route(REQ_PUT, 64'hFFFF_0000_0000_0000, 32'h1);
        send_route(REQ_PUT, 64'h0000_0000_0000_FFF1, 32'h2);
        send_route(REQ_PUT, 64'h0000_1234_1234_0000, 32'h3);
        send_route(REQ_GET, 64'h0000_1234_1234_0000, 32'h0);
        // Miss after walking the chain to an empty slot.
        send_route(REQ_GET, 64'h8000_0000_0000_0000, 32'h0);
        // Last slot and wrap to the front of the table.
        send_route(REQ_PUT, 64'h0000_0000_0000_03FF, 32'h4);
        send_route(REQ_PUT, 64'h0000_0000_0000_07FF, 32'h5);
        send_route(REQ_GET, 64'h0000_0000_0000_07FF, 32'h0);
        // Miss after wrap; path_in on a get must not leak out.
        send_route(REQ_GET, 64'h0000_0000_0000_0BFF, '1);
        // Hash above the prime collides with the all-ones key.
        send_route(REQ_PUT, 64'h0000_0000_0000_FFFF, 32'h6);
        send_route(REQ_GET, 64'h0000_0000_0000_FFFF, 32'h0);
        // Overwrite a wrapped entry, then read back.
        send_route(REQ_PUT, 64'h0000_0000_0000_07FF, '1);
        send_route(REQ_GET, 64'h0000_0000_0000_07FF, 32'h0);
        send_route(REQ_GET, 64'hFFFF_0000_0000_0000, 32'h0);

        // Random traffic on a partly filled table.
        mixed_traffic(700, 35);

        // Fill the table, spreading home slots so clusters merge.
        fill_slot = 0;
        while (stored_keys.num() < SLOTS)
        begin
            send_route(REQ_PUT, fresh_key(int'(fill_slot)), $urandom);
            fill_slot = (fill_slot + 7) % SLOTS;
        end

        // Full table: new puts fail, absent gets walk every slot.
        mixed_traffic(150, 25);
        req_valid <= 1'b0;

        // Drain: let the checker see the last transfer, then wait for all
        // replies and watch for strays before the verdict.
        @(posedge clk);
        while (replies_due != 0) @(posedge clk);
        repeat (SLOTS + 16) @(posedge clk);
        if (mismatch_count == 0 && replies_due == 0)
        begin
            $display("tb_linear_probe_route_table: PASS");
        end
        else
        begin
            $display("tb_linear_probe_route_table: FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #30_000_000;
        $display("tb_linear_probe_route_table: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/lprt_pkg.sv
design/lprt_slot_ram.sv
design/lprt_hash.sv
design/linear_probe_route_table.sv
tb/lprt_route_checker.sv
tb/tb_linear_probe_route_table.sv
